[rtl/core/dtwa_pkg.sv]
// shared types and constants for the device table with aging
// no dependencies
package dtwa_pkg;

  localparam int ADDR_W          = 48;
  localparam int RSSI_W          = 8;
  localparam int TIME_W          = 32;
  localparam int MAX_DEVICES_DEF = 16;
  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd30000;

  // result kinds
  localparam logic [1:0] KIND_DISCOVERED = 2'd0;
  localparam logic [1:0] KIND_SEEN       = 2'd1;
  localparam logic [1:0] KIND_LOST       = 2'd2;
  localparam logic [1:0] KIND_DROPPED    = 2'd3;

  // table write sources
  localparam logic [1:0] WR_HIT    = 2'd0;
  localparam logic [1:0] WR_APPEND = 2'd1;
  localparam logic [1:0] WR_KEEP   = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [RSSI_W-1:0] rssi;
    logic [TIME_W-1:0] seen;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       inc_i;
    logic       inc_keep;
    logic       inc_count;
    logic       set_count_keep;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       pend_load;
    logic       out_load;
    logic       out_from_pend;
    logic [1:0] out_kind;
    logic       out_last;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode;
    logic at_end;
    logic match;
    logic aged;
    logic full;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

[rtl/core/dtwa_ram.sv]
// generic single write, single read ram with registered read
// no dependencies
module dtwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/dtwa_ctrl.sv]
// controller state machine for the device table
// depends on dtwa_pkg
module dtwa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  dtwa_pkg::sts_t  sts,
  output dtwa_pkg::cmd_t  cmd
);
  import dtwa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_EVAL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        state_next = sts.at_end ? S_DONE : S_EVAL;
      end
      S_EVAL: begin
        if (!sts.mode) begin
          if (sts.match) begin
            if (sts.out_free) begin
              cmd.wr_en    = 1'b1;
              cmd.wr_sel   = WR_HIT;
              cmd.out_load = 1'b1;
              cmd.out_kind = KIND_SEEN;
              cmd.out_last = 1'b1;
              state_next   = S_IDLE;
            end
          end else begin
            cmd.inc_i  = 1'b1;
            state_next = S_SCAN;
          end
        end else if (sts.aged) begin
          // the held lost word goes out once a later one is found
          if (!sts.pend_valid || sts.out_free) begin
            cmd.out_load      = sts.pend_valid;
            cmd.out_from_pend = 1'b1;
            cmd.out_kind      = KIND_LOST;
            cmd.pend_load     = 1'b1;
            cmd.inc_i         = 1'b1;
            state_next        = S_SCAN;
          end
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.wr_sel   = WR_KEEP;
          cmd.inc_keep = 1'b1;
          cmd.inc_i    = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_DONE: begin
        if (!sts.mode) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
            if (sts.full) begin
              cmd.out_kind = KIND_DROPPED;
            end else begin
              cmd.out_kind  = KIND_DISCOVERED;
              cmd.wr_en     = 1'b1;
              cmd.wr_sel    = WR_APPEND;
              cmd.inc_count = 1'b1;
            end
            state_next = S_IDLE;
          end
        end else begin
          cmd.set_count_keep = 1'b1;
          if (!sts.pend_valid) begin
            state_next = S_IDLE;
          end else if (sts.out_free) begin
            cmd.out_load      = 1'b1;
            cmd.out_from_pend = 1'b1;
            cmd.out_kind      = KIND_LOST;
            cmd.out_last      = 1'b1;
            state_next        = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/core/dtwa_dp.sv]
// datapath: table memory, scan counters, held lost word, output register
// depends on dtwa_pkg and dtwa_ram
module dtwa_dp #(
  parameter int MAX_DEVICES = dtwa_pkg::MAX_DEVICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dtwa_pkg::TIME_W-1:0]        cfg_wdata,
  input  logic                               mode,
  input  logic [dtwa_pkg::ADDR_W-1:0]        address,
  input  logic signed [dtwa_pkg::RSSI_W-1:0] rssi,
  input  logic [dtwa_pkg::TIME_W-1:0]        now_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         kind,
  output logic [dtwa_pkg::ADDR_W-1:0]        dev_address,
  output logic signed [dtwa_pkg::RSSI_W-1:0] dev_rssi,
  output logic                               last,
  input  dtwa_pkg::cmd_t                     cmd,
  output dtwa_pkg::sts_t                     sts
);
  import dtwa_pkg::*;

  localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNT_W = $clog2(MAX_DEVICES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DEVICES);

  logic [TIME_W-1:0] timeout;
  logic              item_mode;
  entry_t            item;
  logic [CNT_W-1:0]  idx, keep, count;
  entry_t            pend;
  logic              pend_valid;
  entry_t            rdata;
  logic              ram_we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  logic [TIME_W-1:0] age;

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_wdata;
    end
  end

  // latched item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_mode    <= mode;
      item.address <= address;
      item.rssi    <= rssi;
      item.seen    <= now_ms;
    end
  end

  // scan index, keep index and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      keep       <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        idx        <= '0;
        keep       <= '0;
        pend_valid <= 1'b0;
      end else begin
        if (cmd.inc_i) idx <= idx + 1'b1;
        if (cmd.inc_keep) keep <= keep + 1'b1;
        if (cmd.pend_load) pend_valid <= 1'b1;
      end
      if (cmd.inc_count) begin
        count <= count + 1'b1;
      end else if (cmd.set_count_keep) begin
        count <= keep;
      end
    end
  end

  // held lost entry
  always_ff @(posedge clk) begin
    if (cmd.pend_load) begin
      pend <= rdata;
    end
  end

  // table write selection
  always_comb begin
    ram_we = cmd.wr_en;
    wdata  = item;
    unique case (cmd.wr_sel)
      WR_HIT:    waddr = idx[IDX_W-1:0];
      WR_APPEND: waddr = count[IDX_W-1:0];
      WR_KEEP: begin
        waddr = keep[IDX_W-1:0];
        wdata = rdata;
      end
      default: begin
        waddr  = idx[IDX_W-1:0];
        ram_we = 1'b0;
      end
    endcase
  end

  dtwa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_DEVICES),
    .AW   (IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx[IDX_W-1:0]),
    .rdata(rdata)
  );

  // status
  assign age            = item.seen - rdata.seen;
  assign sts.mode       = item_mode;
  assign sts.at_end     = (idx == count);
  assign sts.match      = (rdata.address == item.address);
  assign sts.aged       = (age >= timeout);
  assign sts.full       = (count == CNT_MAX);
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = !out_valid || !out_stall;

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind        <= cmd.out_kind;
      last        <= cmd.out_last;
      dev_address <= cmd.out_from_pend ? pend.address : item.address;
      dev_rssi    <= cmd.out_from_pend ? pend.rssi : item.rssi;
    end
  end

endmodule

[rtl/core/device_table_with_aging.sv]
// top level of the device table with aging
// depends on dtwa_pkg, dtwa_ctrl, dtwa_dp (and dtwa_ram below it)
//
//  channel | valid     | stall     | word
//  --------+-----------+-----------+------------------------------------
//  in      | in_valid  | in_stall  | mode, address, rssi, now_ms
//  out     | out_valid | out_stall | kind, dev_address, dev_rssi, last
//  config  | cfg_we    | -         | cfg_wdata (timeout_ms)
//
// one word at a time; the table is walked through a registered-read ram,
// each stored entry read in S_SCAN and checked in S_EVAL; a sighting
// walks up to its match or to the entry count, a sweep walks every
// stored entry, and both can wait on out_stall
// synchronous reset clears the table to empty and timeout to 30000; no
// clearing pass is needed. out_stall holds the output and can pause the walk
module device_table_with_aging #(
  parameter int MAX_DEVICES = dtwa_pkg::MAX_DEVICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [dtwa_pkg::TIME_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               mode,
  input  logic [dtwa_pkg::ADDR_W-1:0]        address,
  input  logic signed [dtwa_pkg::RSSI_W-1:0] rssi,
  input  logic [dtwa_pkg::TIME_W-1:0]        now_ms,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         kind,
  output logic [dtwa_pkg::ADDR_W-1:0]        dev_address,
  output logic signed [dtwa_pkg::RSSI_W-1:0] dev_rssi,
  output logic                               last
);
  import dtwa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dtwa_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  dtwa_dp #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mode       (mode),
    .address    (address),
    .rssi       (rssi),
    .now_ms     (now_ms),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .dev_address(dev_address),
    .dev_rssi   (dev_rssi),
    .last       (last),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
